FILE: rtl/utrb_pkg.sv
`timescale 1ns / 1ps
// Package for the UART transmit/receive ring buffer unit.
// Holds the action and status codes, payload structs and the controller state type.
// No dependencies.
package utrb_pkg;

    // Action codes carried by an input transaction
    typedef enum logic [1:0] {
        ACT_PUT      = 2'd0,
        ACT_GET      = 2'd1,
        ACT_ARRIVE   = 2'd2,
        ACT_TX_READY = 2'd3
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TX_FULL     = 3'd1,
        ST_RX_EMPTY    = 3'd2,
        ST_RX_OVERFLOW = 3'd3,
        ST_TX_IDLE     = 3'd4
    } t_status;

    // Input transaction payload
    typedef struct packed {
        t_action    action;
        logic [7:0] data_in;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic [7:0] data_out;
        logic       line_send;
        logic       read_valid;
        t_status    status;
        logic       tx_busy;
    } t_out_item;

    // Controller state
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

FILE: rtl/utrb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/uart_tx_rx_ring_buffers_unit.sv
`timescale 1ns / 1ps
// UART transmit/receive ring buffer unit: top level.
// Depends on utrb_pkg and utrb_ram (one instance per ring).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one action per
//   transaction: put a byte to send, get a received byte, a byte arriving
//   from the line, or transmitter ready. Each input transaction yields exactly
//   one result transaction on the output channel (o_out_valid / i_out_stall /
//   o_out_item), in order.
//   Put, arrival and the no-data cases of get and transmitter ready produce
//   their result in the cycle after acceptance.
//   A get or transmitter ready that pops a ring reads the ring memory, whose
//   registered read data then passes to the output register. Input stalls
//   while such a read is in progress, so no new transaction is accepted
//   until its result has been formed.
//   The result sits in an output register; a new transaction is accepted
//   while that register is being taken. When the receiver stalls, the result
//   holds and input stalls until it is taken.
//   Reset (synchronous, active low) empties both rings and clears the busy
//   flag; ring memory contents are not cleared.
module uart_tx_rx_ring_buffers_unit
    import utrb_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int TXA_W = $clog2(TX_DEPTH);
    localparam int RXA_W = $clog2(RX_DEPTH);
    localparam int TXC_W = $clog2(TX_DEPTH + 1);
    localparam int RXC_W = $clog2(RX_DEPTH + 1);
    localparam logic [TXA_W-1:0] TX_LAST = TXA_W'(TX_DEPTH - 1);
    localparam logic [RXA_W-1:0] RX_LAST = RXA_W'(RX_DEPTH - 1);
    localparam logic [TXC_W-1:0] TX_FULL = TXC_W'(TX_DEPTH);
    localparam logic [RXC_W-1:0] RX_FULL = RXC_W'(RX_DEPTH);

    t_state           r_state, n_state;
    logic             r_rd_tx, n_rd_tx;
    logic [TXA_W-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [TXC_W-1:0] r_tx_count, n_tx_count;
    logic [RXA_W-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [RXC_W-1:0] r_rx_count, n_rx_count;
    logic             r_busy, n_busy;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             out_free;
    logic             accept;
    logic             tx_we, tx_re, rx_we, rx_re;
    logic [7:0]       tx_rdata, rx_rdata;

    // Ring memories
    utrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (i_in_item.data_in),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    utrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (i_in_item.data_in),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    // Handshake: accept when idle and the output register is free or draining
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Next state, ring pointer updates and result formation
    always_comb begin
        n_state     = r_state;
        n_rd_tx     = r_rd_tx;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_count  = r_tx_count;
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_count  = r_rx_count;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        rx_we       = 1'b0;
        rx_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out             = '0;
                    n_out.status      = ST_OK;
                    n_out_valid       = 1'b1;
                    unique case (i_in_item.action)
                        ACT_PUT: begin
                            if (!r_busy) begin
                                n_out.data_out  = i_in_item.data_in;
                                n_out.line_send = 1'b1;
                                n_busy          = 1'b1;
                            end else if (r_tx_count == TX_FULL) begin
                                n_out.status = ST_TX_FULL;
                            end else begin
                                tx_we      = 1'b1;
                                n_tx_tail  = (r_tx_tail == TX_LAST) ? '0 : r_tx_tail + 1'b1;
                                n_tx_count = r_tx_count + 1'b1;
                            end
                        end
                        ACT_GET: begin
                            if (r_rx_count == '0) begin
                                n_out.status = ST_RX_EMPTY;
                            end else begin
                                rx_re       = 1'b1;
                                n_rx_head   = (r_rx_head == RX_LAST) ? '0 : r_rx_head + 1'b1;
                                n_rx_count  = r_rx_count - 1'b1;
                                n_rd_tx     = 1'b0;
                                n_state     = S_READ;
                                n_out_valid = 1'b0;
                            end
                        end
                        ACT_ARRIVE: begin
                            if (r_rx_count != RX_FULL) begin
                                rx_we      = 1'b1;
                                n_rx_tail  = (r_rx_tail == RX_LAST) ? '0 : r_rx_tail + 1'b1;
                                n_rx_count = r_rx_count + 1'b1;
                            end else begin
                                n_out.status = ST_RX_OVERFLOW;
                            end
                        end
                        ACT_TX_READY: begin
                            if (r_tx_count != '0) begin
                                tx_re       = 1'b1;
                                n_tx_head   = (r_tx_head == TX_LAST) ? '0 : r_tx_head + 1'b1;
                                n_tx_count  = r_tx_count - 1'b1;
                                n_busy      = 1'b1;
                                n_rd_tx     = 1'b1;
                                n_state     = S_READ;
                                n_out_valid = 1'b0;
                            end else begin
                                n_busy       = 1'b0;
                                n_out.status = ST_TX_IDLE;
                            end
                        end
                    endcase
                    n_out.tx_busy = n_busy;
                end
            end
            S_READ: begin
                // RAM data is valid now; output register is known free
                n_out            = '0;
                n_out.data_out   = r_rd_tx ? tx_rdata : rx_rdata;
                n_out.line_send  = r_rd_tx;
                n_out.read_valid = !r_rd_tx;
                n_out.status     = ST_OK;
                n_out.tx_busy    = r_busy;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_tx     <= 1'b0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_count  <= '0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_count  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_tx     <= n_rd_tx;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_count  <= n_tx_count;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_count  <= n_rx_count;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: bench/tb_uart_tx_rx_ring_buffers_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_tx_rx_ring_buffers_unit: drives random and
// directed actions, tracks ring and busy-flag state alongside the block.
// Depends on utrb_pkg and the unit's RTL.
module tb_uart_tx_rx_ring_buffers_unit;
    import utrb_pkg::*;

    localparam int TX_DEPTH      = 16;
    localparam int RX_DEPTH      = 16;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int BURST_LEN     = 40;
    localparam int DRAIN_AT      = 600;
    localparam int QUIET_FROM    = 1000;
    localparam int QUIET_TO      = 1600;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 8;
    localparam int REPORT_LIMIT  = 10;

    // Burst flavors that steer ring occupancy
    typedef enum int {
        MIX_EVEN,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Shadow copy of the buffering state
    logic [7:0] tx_ring [TX_DEPTH];
    logic [7:0] rx_ring [RX_DEPTH];
    logic [$clog2(TX_DEPTH)-1:0] tx_rd_ptr  = '0;
    logic [$clog2(TX_DEPTH):0]   tx_fill    = '0;
    logic [$clog2(RX_DEPTH)-1:0] rx_rd_ptr  = '0;
    logic [$clog2(RX_DEPTH):0]   rx_fill    = '0;
    logic                        line_busy  = 1'b0;

    t_in_item  action_queue [$];
    t_out_item uart_results_due [$];

    int items_launched  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int quiet_count     = 0;
    int cycle_no        = 0;
    bit drain_done      = 1'b0;
    int action_tally [4];
    int status_tally [5];

    uart_tx_rx_ring_buffers_unit #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Applies one action to the shadow state and returns the result it should give
    function automatic t_out_item ring_buffer_outcome(t_in_item it);
        t_out_item r;
        r.data_out   = 8'h00;
        r.line_send  = 1'b0;
        r.read_valid = 1'b0;
        r.status     = ST_OK;
        case (it.action)
            ACT_PUT: begin
                if (!line_busy) begin
                    r.data_out  = it.data_in;
                    r.line_send = 1'b1;
                    line_busy   = 1'b1;
                end else if (tx_fill == TX_DEPTH) begin
                    r.status = ST_TX_FULL;
                end else begin
                    tx_ring[(int'(tx_rd_ptr) + int'(tx_fill)) % TX_DEPTH] = it.data_in;
                    tx_fill++;
                end
            end
            ACT_GET: begin
                if (rx_fill == 0) begin
                    r.status = ST_RX_EMPTY;
                end else begin
                    r.data_out   = rx_ring[rx_rd_ptr];
                    r.read_valid = 1'b1;
                    rx_rd_ptr++;
                    rx_fill--;
                end
            end
            ACT_ARRIVE: begin
                if (rx_fill < RX_DEPTH) begin
                    rx_ring[(int'(rx_rd_ptr) + int'(rx_fill)) % RX_DEPTH] = it.data_in;
                    rx_fill++;
                end else begin
                    r.status = ST_RX_OVERFLOW;
                end
            end
            default: begin
                if (tx_fill != 0) begin
                    line_busy   = 1'b1;
                    r.data_out  = tx_ring[tx_rd_ptr];
                    r.line_send = 1'b1;
                    tx_rd_ptr++;
                    tx_fill--;
                end else begin
                    line_busy = 1'b0;
                    r.status  = ST_TX_IDLE;
                end
            end
        endcase
        r.tx_busy = line_busy;
        return r;
    endfunction

    function automatic void queue_action(t_action a, logic [7:0] d);
        t_in_item it;
        it.action  = a;
        it.data_in = d;
        action_queue.push_back(it);
    endfunction

    // Picks an action weighted by the burst flavor, with a random byte
    function automatic void queue_random_action(t_mix mix);
        int roll;
        int w_put;
        int w_arrive;
        int w_get;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                w_put = 45; w_arrive = 45; w_get = 5;
            end
            MIX_DRAIN: begin
                w_put = 5; w_arrive = 5; w_get = 45;
            end
            default: begin
                w_put = 25; w_arrive = 25; w_get = 25;
            end
        endcase
        if (roll < w_put)
            queue_action(ACT_PUT, 8'($urandom_range(255)));
        else if (roll < w_put + w_arrive)
            queue_action(ACT_ARRIVE, 8'($urandom_range(255)));
        else if (roll < w_put + w_arrive + w_get)
            queue_action(ACT_GET, 8'($urandom_range(255)));
        else
            queue_action(ACT_TX_READY, 8'($urandom_range(255)));
    endfunction

    // Cycle counter for the no-idle window
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Input driver: records accepted transactions and launches the next one
    always @(posedge i_clk) begin
        bit go;
        bit took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                uart_results_due.push_back(ring_buffer_outcome(i_in_item));
                action_tally[i_in_item.action]++;
                items_accepted++;
            end
            if (!i_in_valid || took) begin
                go = action_queue.size() != 0;
                if (!(cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) &&
                    $urandom_range(99) < 33)
                    go = 1'b0;
                // Hold off once until the output side has caught up
                if (items_launched == DRAIN_AT && !drain_done) begin
                    if (uart_results_due.size() == 0)
                        drain_done = 1'b1;
                    else
                        go = 1'b0;
                end
                if (go) begin
                    i_in_item <= action_queue.pop_front();
                    items_launched++;
                end
                i_in_valid <= go;
            end
        end
    end

    // Output monitor: compares each result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_item;
                if (uart_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: data_out=%02h send=%b rvalid=%b status=%0d busy=%b",
                                 got.data_out, got.line_send, got.read_valid,
                                 got.status, got.tx_busy);
                end else begin
                    want = uart_results_due.pop_front();
                    results_checked++;
                    status_tally[want.status]++;
                    if (got.data_out !== want.data_out || got.line_send !== want.line_send ||
                        got.read_valid !== want.read_valid || got.status !== want.status ||
                        got.tx_busy !== want.tx_busy) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch on result %0d: exp %02h/%b/%b/%0d/%b got %02h/%b/%b/%0d/%b",
                                     results_checked, want.data_out, want.line_send,
                                     want.read_valid, want.status, want.tx_busy,
                                     got.data_out, got.line_send, got.read_valid,
                                     got.status, got.tx_busy);
                    end
                end
            end
            i_out_stall <= !(cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) &&
                           ($urandom_range(99) < 33);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_count);
            $display("FAIL uart_tx_rx_ring_buffers_unit");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        t_mix mix;

        // Directed: straight send, queueing, pops, idle twice, empty get
        queue_action(ACT_PUT, 8'h00);
        queue_action(ACT_PUT, 8'hFF);
        queue_action(ACT_PUT, 8'h5A);
        queue_action(ACT_TX_READY, 8'h00);
        queue_action(ACT_TX_READY, 8'hFF);
        queue_action(ACT_TX_READY, 8'h00);
        queue_action(ACT_TX_READY, 8'h00);
        queue_action(ACT_GET, 8'hFF);
        queue_action(ACT_ARRIVE, 8'hFF);
        queue_action(ACT_ARRIVE, 8'h00);
        queue_action(ACT_GET, 8'h00);
        queue_action(ACT_GET, 8'h00);
        queue_action(ACT_GET, 8'h00);
        queue_action(ACT_PUT, 8'h81);
        queue_action(ACT_TX_READY, 8'h7E);

        // Random bursts; the first one is weighted to fill both rings
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 0)
                mix = MIX_FILL;
            else if (n % BURST_LEN == 0)
                mix = t_mix'($urandom_range(2));
            queue_random_action(mix);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (action_queue.size() != 0 || i_in_valid || uart_results_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (uart_results_due.size() != 0) begin
            $display("%0d results never arrived", uart_results_due.size());
            mismatch_count += uart_results_due.size();
        end

        $display("covered %0d transactions: put %0d, get %0d, arrive %0d, ready %0d",
                 items_accepted, action_tally[ACT_PUT], action_tally[ACT_GET],
                 action_tally[ACT_ARRIVE], action_tally[ACT_TX_READY]);
        $display("refused puts %0d, empty gets %0d, overflow drops %0d, idle readies %0d",
                 status_tally[ST_TX_FULL], status_tally[ST_RX_EMPTY],
                 status_tally[ST_RX_OVERFLOW], status_tally[ST_TX_IDLE]);
        if (mismatch_count == 0) begin
            $display("PASS uart_tx_rx_ring_buffers_unit");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL uart_tx_rx_ring_buffers_unit");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/utrb_pkg.sv
rtl/utrb_ram.sv
rtl/uart_tx_rx_ring_buffers_unit.sv
bench/tb_uart_tx_rx_ring_buffers_unit.sv
